[rtl/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, constants and the exponent table for the sample mutation
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int V_W             = 24;

  localparam int COORD_W = 32;
  localparam int RAND_W  = 24;
  localparam int T_W     = RAND_W + 1;
  localparam int K_W     = 21;
  localparam int E_W     = K_W + T_W - 1;
  localparam int IP_W    = 5;
  localparam int PROD_W  = COORD_W + V_W;
  localparam int DX_W    = 34;
  localparam int X_W     = 37;
  localparam int ADJ_W   = COORD_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  localparam logic [1:0] MODE_UNIT = 2'd0;
  localparam logic [1:0] MODE_X    = 2'd1;
  localparam logic [1:0] MODE_Y    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_X_START       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_END         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_START       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_END         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RANGE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOG_TWO = 3'd5;

  localparam logic [COORD_W-1:0] UNIT_BASE = 32'd4096;
  localparam logic [K_W-1:0]     UNIT_K    = 21'd393216;
  localparam logic [COORD_W-1:0] UNIT_HI   = 32'd65536;
  localparam logic [T_W-1:0]     ONE_T     = 25'd16777216;

  typedef logic [V_W-1:0] exp_table_t [EXP_TABLE_DEPTH];

  // 2^(-i/DEPTH) from the series of exp(-y), Q32, rounded to Q1.23
  function automatic exp_table_t build_exp_table();
    exp_table_t  tbl;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      y    = (64'(i) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
      term = 64'd1 << 32;
      pos  = term;
      neg  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * y) >> 32) / 64'(n);
        if ((n % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      tbl[i] = V_W'(((pos - neg) + 64'd256) >> 9);
    end
    return tbl;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

[rtl/primary_sample_mutation_top.sv]
// ----------------------------------------------------------------------------
// primary_sample_mutation_top
// Small-step mutation of one Q16.16 sample coordinate with a 2^-x step size.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle when not stalled; each stage holds one word
// and its valid bit.
// The step table read and the 32x24 multiply each take a stage of their own.
// Reset clears all stage valid bits and loads the register defaults.
`default_nettype none

module primary_sample_mutation_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         mode,
  input  wire logic [psm_pkg::COORD_W-1:0]        coord_in,
  input  wire logic [psm_pkg::RAND_W-1:0]         rand_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [psm_pkg::COORD_W-1:0]             coord_out,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [psm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  // configuration
  logic [15:0]                  x_start;
  logic [15:0]                  x_end;
  logic [15:0]                  y_start;
  logic [15:0]                  y_end;
  logic [psm_pkg::COORD_W-1:0]  step_range;
  logic [psm_pkg::K_W-1:0]      range_log_two;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start       <= 16'd0;
      x_end         <= 16'd640;
      y_start       <= 16'd0;
      y_end         <= 16'd480;
      step_range    <= 32'd1835008;
      range_log_two <= 21'd310997;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psm_pkg::REG_X_START:       x_start       <= cfg_data[15:0];
        psm_pkg::REG_X_END:         x_end         <= cfg_data[15:0];
        psm_pkg::REG_Y_START:       y_start       <= cfg_data[15:0];
        psm_pkg::REG_Y_END:         y_end         <= cfg_data[15:0];
        psm_pkg::REG_STEP_RANGE:    step_range    <= cfg_data;
        psm_pkg::REG_RANGE_LOG_TWO: range_log_two <= cfg_data[psm_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7      = !v7 || !out_stall;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // stage 1: mode select, |2r-1|
  logic [psm_pkg::COORD_W-1:0]     sel_lo;
  logic [psm_pkg::COORD_W-1:0]     sel_hi;
  logic [psm_pkg::COORD_W-1:0]     sel_base;
  logic [psm_pkg::K_W-1:0]         sel_k;
  logic [psm_pkg::T_W-1:0]         r2;
  logic [psm_pkg::T_W-1:0]         t_in;
  logic                            sub_in;
  logic signed [psm_pkg::ADJ_W-1:0] adj_in;

  always_comb begin
    case (mode)
      psm_pkg::MODE_X: begin
        sel_lo   = {x_start, 16'd0};
        sel_hi   = {x_end, 16'd0};
        sel_base = step_range;
        sel_k    = range_log_two;
      end
      psm_pkg::MODE_Y: begin
        sel_lo   = {y_start, 16'd0};
        sel_hi   = {y_end, 16'd0};
        sel_base = step_range;
        sel_k    = range_log_two;
      end
      default: begin
        sel_lo   = '0;
        sel_hi   = psm_pkg::UNIT_HI;
        sel_base = psm_pkg::UNIT_BASE;
        sel_k    = psm_pkg::UNIT_K;
      end
    endcase
    r2     = {rand_value, 1'b0};
    t_in   = (r2 >= psm_pkg::ONE_T) ? (r2 - psm_pkg::ONE_T) : (psm_pkg::ONE_T - r2);
    sub_in = rand_value[psm_pkg::RAND_W-1];
    adj_in = sub_in ? ($signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo}))
                    : ($signed({1'b0, sel_lo}) - $signed({1'b0, sel_hi}));
  end

  logic [psm_pkg::T_W-1:0]          s1_t;
  logic [psm_pkg::K_W-1:0]          s1_k;
  logic [psm_pkg::COORD_W-1:0]      s1_base, s1_lo, s1_hi, s1_x;
  logic signed [psm_pkg::ADJ_W-1:0] s1_adj;
  logic                             s1_sub;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_t    <= t_in;
      s1_k    <= sel_k;
      s1_base <= sel_base;
      s1_lo   <= sel_lo;
      s1_hi   <= sel_hi;
      s1_x    <= coord_in;
      s1_adj  <= adj_in;
      s1_sub  <= sub_in;
    end
  end

  // stage 2: exponent k*t
  logic [psm_pkg::E_W-1:0] e_prod;
  assign e_prod = psm_pkg::E_W'(s1_k) * psm_pkg::E_W'(s1_t);

  logic [psm_pkg::IP_W-1:0]         s2_ip;
  logic [psm_pkg::IDX_W-1:0]        s2_idx;
  logic [psm_pkg::COORD_W-1:0]      s2_base, s2_lo, s2_hi, s2_x;
  logic signed [psm_pkg::ADJ_W-1:0] s2_adj;
  logic                             s2_sub;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ip   <= e_prod[40 +: psm_pkg::IP_W];
      s2_idx  <= e_prod[39 -: psm_pkg::IDX_W];
      s2_base <= s1_base;
      s2_lo   <= s1_lo;
      s2_hi   <= s1_hi;
      s2_x    <= s1_x;
      s2_adj  <= s1_adj;
      s2_sub  <= s1_sub;
    end
  end

  // stage 3: table read
  logic [psm_pkg::V_W-1:0]          s3_v;
  logic [psm_pkg::IP_W-1:0]         s3_ip;
  logic [psm_pkg::COORD_W-1:0]      s3_base, s3_lo, s3_hi, s3_x;
  logic signed [psm_pkg::ADJ_W-1:0] s3_adj;
  logic                             s3_sub;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_v    <= psm_pkg::EXP_TABLE[s2_idx];
      s3_ip   <= s2_ip;
      s3_base <= s2_base;
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
      s3_x    <= s2_x;
      s3_adj  <= s2_adj;
      s3_sub  <= s2_sub;
    end
  end

  // stage 4: base * 2^-f
  logic [psm_pkg::PROD_W-1:0]       s4_prod;
  logic [psm_pkg::IP_W-1:0]         s4_ip;
  logic [psm_pkg::COORD_W-1:0]      s4_lo, s4_hi, s4_x;
  logic signed [psm_pkg::ADJ_W-1:0] s4_adj;
  logic                             s4_sub;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_prod <= psm_pkg::PROD_W'(s3_base) * psm_pkg::PROD_W'(s3_v);
      s4_ip   <= s3_ip;
      s4_lo   <= s3_lo;
      s4_hi   <= s3_hi;
      s4_x    <= s3_x;
      s4_adj  <= s3_adj;
      s4_sub  <= s3_sub;
    end
  end

  // stage 5: rounded shift by 23+ip
  logic [5:0]                  sh;
  logic [psm_pkg::PROD_W-1:0]  shifted;
  logic [psm_pkg::DX_W:0]      rnd;

  assign sh      = 6'd22 + 6'(s4_ip);
  assign shifted = s4_prod >> sh;
  assign rnd     = (psm_pkg::DX_W + 1)'(shifted[psm_pkg::DX_W-1:0]) + 1'b1;

  logic [psm_pkg::DX_W-1:0]         s5_dx;
  logic [psm_pkg::COORD_W-1:0]      s5_lo, s5_hi, s5_x;
  logic signed [psm_pkg::ADJ_W-1:0] s5_adj;
  logic                             s5_sub;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_dx  <= rnd[psm_pkg::DX_W:1];
      s5_lo  <= s4_lo;
      s5_hi  <= s4_hi;
      s5_x   <= s4_x;
      s5_adj <= s4_adj;
      s5_sub <= s4_sub;
    end
  end

  // stage 6: x +/- dx
  logic signed [psm_pkg::X_W-1:0] xe;
  logic signed [psm_pkg::X_W-1:0] dxe;

  assign xe  = $signed({5'd0, s5_x});
  assign dxe = $signed({3'd0, s5_dx});

  function automatic logic signed [psm_pkg::X_W-1:0] s6_sub_sel(
    input logic                            sub,
    input logic signed [psm_pkg::X_W-1:0]  a,
    input logic signed [psm_pkg::X_W-1:0]  b
  );
    return sub ? (a - b) : (a + b);
  endfunction

  logic signed [psm_pkg::X_W-1:0]   s6_x1;
  logic [psm_pkg::COORD_W-1:0]      s6_lo, s6_hi;
  logic signed [psm_pkg::ADJ_W-1:0] s6_adj;
  logic                             s6_sub;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_x1  <= s6_sub_sel(s5_sub, xe, dxe);
      s6_lo  <= s5_lo;
      s6_hi  <= s5_hi;
      s6_adj <= s5_adj;
      s6_sub <= s5_sub;
    end
  end

  // stage 7: wrap once, saturate
  logic signed [psm_pkg::X_W-1:0] lo_e, hi_e, adj_e, x1w;
  logic                           wrap;
  logic [psm_pkg::COORD_W-1:0]    clamped;

  always_comb begin
    lo_e  = $signed({5'd0, s6_lo});
    hi_e  = $signed({5'd0, s6_hi});
    adj_e = $signed({{(psm_pkg::X_W - psm_pkg::ADJ_W){s6_adj[psm_pkg::ADJ_W-1]}}, s6_adj});
    wrap  = s6_sub ? (s6_x1 < lo_e) : (s6_x1 > hi_e);
    x1w   = wrap ? (s6_x1 + adj_e) : s6_x1;
    if (x1w[psm_pkg::X_W-1]) begin
      clamped = '0;
    end else if (x1w[psm_pkg::X_W-2:psm_pkg::COORD_W] != '0) begin
      clamped = '1;
    end else begin
      clamped = x1w[psm_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      coord_out <= clamped;
    end
  end

  assign out_valid = v7;

endmodule

`default_nettype wire

[rtl/psm_checker.sv]
// ----------------------------------------------------------------------------
// psm_checker
// Port-level checks for the sample mutation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] coord_out,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coord_out))
    else $error("output word changed while stalled");

  // empty output stage means the whole pipe can move
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  // reset flushes the pipe
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // an input word only waits behind a held output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind primary_sample_mutation_top psm_checker u_psm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .coord_out (coord_out),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

[tb/sv/primary_sample_mutation_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primary_sample_mutation_top_tb
// Checks the small-step coordinate mutation against an in-bench predictor.
// Words pass through random sender gaps and receiver stalls, under the reset
// register values and several other settings, extremes among them.
// ----------------------------------------------------------------------------

module primary_sample_mutation_top_tb;
  import psm_pkg::*;

  localparam logic [1:0]  MODE_SPARE     = 2'd3;
  localparam int          WORDS_PER_SET  = 200;
  localparam int          SETTING_COUNT  = 8;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam logic [63:0] FRAC40_MASK    = (64'd1 << 40) - 64'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] coord;
    logic [RAND_W-1:0]  rnd;
  } mut_word_t;

  typedef struct packed {
    mut_word_t          src;
    logic [COORD_W-1:0] coord;
  } mut_result_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [1:0]           mode       = '0;
  logic [COORD_W-1:0]   coord_in   = '0;
  logic [RAND_W-1:0]    rand_value = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [COORD_W-1:0]   coord_out;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;

  primary_sample_mutation_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .coord_in   (coord_in),
    .rand_value (rand_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coord_out  (coord_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [V_W-1:0] pow2_frac [EXP_TABLE_DEPTH];
  logic [15:0]    x_lo_px   = 16'd0;
  logic [15:0]    x_hi_px   = 16'd640;
  logic [15:0]    y_lo_px   = 16'd0;
  logic [15:0]    y_hi_px   = 16'd480;
  logic [31:0]    step_span = 32'd1835008;
  logic [20:0]    span_log2 = 21'd310997;

  mut_word_t   word_q[$];
  mut_result_t coord_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int words_sent    = 0;
  int unit_words    = 0;
  int axis_words    = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;
  logic in_taken    = 1'b0;

  function automatic logic [COORD_W-1:0] mutate_coord(mut_word_t w);
    logic [63:0] r64, t, k, base, e, ip, idx, prod, sh, dx;
    longint      lo, hi, x1;
    if (w.mode == MODE_X || w.mode == MODE_Y) begin
      lo   = longint'({(w.mode == MODE_X) ? x_lo_px : y_lo_px, 16'h0000});
      hi   = longint'({(w.mode == MODE_X) ? x_hi_px : y_hi_px, 16'h0000});
      base = 64'(step_span);
      k    = 64'(span_log2);
    end else begin
      lo   = 0;
      hi   = 65536;
      base = 64'd4096;
      k    = 64'd6 << 16;
    end
    r64 = 64'(w.rnd);
    t   = (2 * r64 >= (64'd1 << 24)) ? (2 * r64 - (64'd1 << 24))
                                     : ((64'd1 << 24) - 2 * r64);
    e   = k * t;
    ip  = e >> 40;
    idx = ((e & FRAC40_MASK) * 64'(EXP_TABLE_DEPTH)) >> 40;
    if (idx >= 64'(EXP_TABLE_DEPTH)) begin
      idx = 64'(EXP_TABLE_DEPTH - 1);
    end
    prod = base * 64'(pow2_frac[idx]);
    sh   = 64'd23 + ip;
    dx   = (prod + (64'd1 << (sh - 1))) >> sh;
    if (w.rnd < (RAND_W'(1) << (RAND_W - 1))) begin
      x1 = longint'(w.coord) + longint'(dx);
      if (x1 > hi) begin
        x1 = x1 - hi + lo;
      end
    end else begin
      x1 = longint'(w.coord) - longint'(dx);
      if (x1 < lo) begin
        x1 = x1 - lo + hi;
      end
    end
    if (x1 < 0) begin
      x1 = 0;
    end
    if (x1 > longint'(32'hFFFF_FFFF)) begin
      x1 = longint'(32'hFFFF_FFFF);
    end
    return COORD_W'(x1);
  endfunction

  function automatic mut_word_t random_word();
    mut_word_t   w;
    int          pick;
    logic [15:0] a, b;
    logic [31:0] lo_q, hi_q, bound;
    w.mode = 2'($urandom_range(3));
    if (w.mode == MODE_X || w.mode == MODE_Y) begin
      a    = (w.mode == MODE_X) ? x_lo_px : y_lo_px;
      b    = (w.mode == MODE_X) ? x_hi_px : y_hi_px;
      lo_q = {((a < b) ? a : b), 16'h0000};
      hi_q = {((a < b) ? b : a), 16'h0000};
    end else begin
      lo_q = 32'd0;
      hi_q = 32'd65536;
    end
    pick = $urandom_range(9);
    if (pick < 6) begin
      w.coord = $urandom_range(hi_q, lo_q);
    end else if (pick < 8) begin
      bound   = $urandom_range(1) ? hi_q : lo_q;
      w.coord = bound + 32'($urandom_range(64)) - 32'd32;
    end else begin
      w.coord = $urandom;
    end
    case ($urandom_range(19))
      0:       w.rnd = '0;
      1:       w.rnd = '1;
      2:       w.rnd = RAND_W'(1) << (RAND_W - 1);
      3:       w.rnd = (RAND_W'(1) << (RAND_W - 1)) - RAND_W'(1);
      default: w.rnd = RAND_W'($urandom);
    endcase
    return w;
  endfunction

  task automatic queue_word(input logic [1:0] m, input logic [31:0] c,
                            input logic [RAND_W-1:0] r);
    word_q.push_back('{mode: m, coord: c, rnd: r});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_START:       x_lo_px   = data[15:0];
      REG_X_END:         x_hi_px   = data[15:0];
      REG_Y_START:       y_lo_px   = data[15:0];
      REG_Y_END:         y_hi_px   = data[15:0];
      REG_STEP_RANGE:    step_span = data;
      REG_RANGE_LOG_TWO: span_log2 = data[20:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until the pipe is empty
  task automatic drain();
    while (word_q.size() != 0 || in_valid || coord_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d words pending", cycle_count, coord_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        mode       <= word_q[0].mode;
        coord_in   <= word_q[0].coord;
        rand_value <= word_q[0].rnd;
        void'(word_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    mut_word_t   w;
    mut_result_t exp_r;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        w = '{mode: mode, coord: coord_in, rnd: rand_value};
        coord_q.push_back('{src: w, coord: mutate_coord(w)});
        words_sent++;
        if (w.mode == MODE_X || w.mode == MODE_Y) begin
          axis_words++;
        end else begin
          unit_words++;
        end
      end
      if (out_valid && !out_stall) begin
        if (coord_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected word: coord_out=%h", coord_out);
          end
        end else begin
          exp_r = coord_q.pop_front();
          if (coord_out !== exp_r.coord) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: mode=%0d coord_in=%h rand=%h expected=%h actual=%h",
                       exp_r.src.mode, exp_r.src.coord, exp_r.src.rnd, exp_r.coord,
                       coord_out);
            end
          end
        end
      end
    end
  end

  initial begin
    logic [63:0] y, term, pos, neg;
    logic [15:0] a;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      y    = (64'(i) * 64'd2977044472) / 64'(EXP_TABLE_DEPTH);
      term = 64'd1 << 32;
      pos  = term;
      neg  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * y) >> 32) / 64'(n);
        if (n % 2 == 1) begin
          neg += term;
        end else begin
          pos += term;
        end
      end
      pow2_frac[i] = V_W'(((pos - neg) + 64'd256) >> 9);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under reset register values
    queue_word(MODE_UNIT, 32'd0, 24'h000000);
    queue_word(MODE_UNIT, 32'd0, 24'hFFFFFF);
    queue_word(MODE_UNIT, 32'd65536, 24'h000000);
    queue_word(MODE_UNIT, 32'd0, 24'h800000);
    queue_word(MODE_UNIT, 32'hFFFF_FFFF, 24'h7FFFFF);
    queue_word(MODE_UNIT, 32'hFFFF_FFFF, 24'h000000);
    queue_word(MODE_UNIT, 32'd32768, 24'h400000);
    queue_word(MODE_SPARE, 32'd32768, 24'h003039);
    queue_word(MODE_SPARE, 32'd0, 24'h800001);
    queue_word(MODE_SPARE, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_word(MODE_X, 32'd640 << 16, 24'h100000);
    queue_word(MODE_X, 32'd0, 24'hF00000);
    queue_word(MODE_X, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_word(MODE_X, 32'd320 << 16, 24'h7FFFFF);
    queue_word(MODE_X, 32'd0, 24'h000000);
    queue_word(MODE_Y, 32'd480 << 16, 24'h000000);
    queue_word(MODE_Y, 32'd0, 24'h800000);
    queue_word(MODE_Y, 32'h1234_5678, 24'h800001);
    queue_word(MODE_Y, 32'hFFFF_FFFF, 24'h000000);
    queue_word(MODE_Y, 32'd240 << 16, 24'hC00000);

    for (int p = 0; p < SETTING_COUNT; p++) begin
      if (p < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 72;
      end else if (p < 6) begin
        send_idle_pct = 72;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) begin
        drain();
        case (p)
          1: begin
            write_reg(REG_X_START, 32'd0);
            write_reg(REG_X_END, 32'd65535);
            write_reg(REG_Y_START, 32'd65535);
            write_reg(REG_Y_END, 32'd0);
            write_reg(REG_STEP_RANGE, 32'hFFFF_FFFF);
            write_reg(REG_RANGE_LOG_TWO, 32'h001F_FFFF);
          end
          2: begin
            write_reg(REG_X_START, 32'd0);
            write_reg(REG_X_END, 32'd0);
            write_reg(REG_Y_START, 32'd0);
            write_reg(REG_Y_END, 32'd0);
            write_reg(REG_STEP_RANGE, 32'd0);
            write_reg(REG_RANGE_LOG_TWO, 32'd0);
          end
          3: begin
            write_reg(REG_X_START, {16'($urandom), 16'd300});
            write_reg(REG_X_END, {16'($urandom), 16'd100});
            write_reg(REG_Y_START, {16'($urandom), 16'd1000});
            write_reg(REG_Y_END, {16'($urandom), 16'd999});
            write_reg(REG_STEP_RANGE, 32'd4 << 16);
            write_reg(REG_RANGE_LOG_TWO, {11'($urandom), 21'd196608});
          end
          default: begin
            a = 16'($urandom_range(2000));
            write_reg(REG_X_START, {16'($urandom), a});
            write_reg(REG_X_END, {16'($urandom), a + 16'($urandom_range(4000))});
            a = 16'($urandom_range(2000));
            write_reg(REG_Y_START, {16'($urandom), a});
            write_reg(REG_Y_END, {16'($urandom), a + 16'($urandom_range(4000))});
            write_reg(REG_STEP_RANGE, $urandom_range(32'h0040_0000));
            write_reg(REG_RANGE_LOG_TWO, {11'($urandom),
                      ($urandom_range(3) == 0) ? 21'h1F_FFFF : 21'($urandom_range(1179647))});
          end
        endcase
      end
      for (int i = 0; i < WORDS_PER_SET; i++) begin
        word_q.push_back(random_word());
      end
    end
    drain();

    $display("%0d words checked (%0d unit, %0d axis) over %0d register settings",
             words_sent, unit_words, axis_words, SETTING_COUNT);
    $display("%0d register writes, %0d failures", reg_writes, fail_count + coord_q.size());
    if (fail_count == 0 && coord_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[primary_sample_mutation_top.f]
rtl/psm_pkg.sv
rtl/primary_sample_mutation_top.sv
rtl/psm_checker.sv
tb/sv/primary_sample_mutation_top_tb.sv
